>>> rtl/nfwlz_pkg.sv
package nfwlz_pkg;

	localparam int unsigned WORD_W            = 16;
	localparam int unsigned BYTE_W            = 8;
	localparam int unsigned OUT_LANES         = 4;
	localparam int unsigned COUNT_W           = 3;
	localparam int unsigned POS_W             = 16;
	localparam int unsigned SRC_W             = 18;

	localparam int unsigned HISTORY_WORDS_DEF = 8192;
	localparam int unsigned GROUP_WORDS_DEF   = 4;

	localparam logic [BYTE_W-1:0] NEAR_TAG = 8'hA7;
	localparam logic [BYTE_W-1:0] FAR_TAG  = 8'hA8;

endpackage

>>> rtl/near_far_word_lz_expander_core.sv
// A literal or escaped word passes the word stage register, then enters the output register once it is free.
// Input: a parser-only byte every cycle; a literal or escape holds the input off until its word
// is handed to the output register. A copy holds it off while it reads the RAM once per word,
// hands each group to the output register and goes idle, and while the output stalls.
// Reset (arst_n low) clears parser, position, flags and handshakes at once; history RAM is not
// cleared, a read is trusted only below the current write position.
module near_far_word_lz_expander_core import nfwlz_pkg::*; #(
	parameter int unsigned HISTORY_WORDS = HISTORY_WORDS_DEF,
	parameter int unsigned GROUP_WORDS   = GROUP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: expanded_bytes
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] start_stream
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [15:0] word_0, [31:16] word_1, [47:32] word_2,
	                                    // [63:48] word_3, [66:64] word_count, [71:67] zero
	output logic        m_axis_tlast,   // run_last
	output logic [1:0]  m_axis_tuser    // [0] stream_done, [1] bad_reference
);

	localparam int unsigned AW = (HISTORY_WORDS > 1) ? $clog2(HISTORY_WORDS) : 1;
	localparam logic [POS_W-1:0]   HW_POS = POS_W'(HISTORY_WORDS);
	localparam logic [SRC_W-2:0]   HW_SRC = (SRC_W-1)'(HISTORY_WORDS);
	localparam logic [COUNT_W-1:0] GW_CNT = COUNT_W'(GROUP_WORDS);

	typedef enum logic [2:0] {
		PH_LOW, PH_HIGH, PH_ESCAPE, PH_NEAR_DIST, PH_FAR_LO, PH_FAR_HI
	} phase_t;

	typedef enum logic {CT_IDLE, CT_RUN} ctl_t;

	// history RAM: one write, one registered read per cycle
	logic [WORD_W-1:0] hist_mem [HISTORY_WORDS];
	logic [WORD_W-1:0] rd_q;

	// configuration and parser
	logic [15:0]        expanded_q;
	phase_t             phase_q;
	ctl_t               ct_q;
	logic [BYTE_W-1:0]  held_low_q;
	logic               kind_q;       // 0 near, 1 far
	logic [BYTE_W-1:0]  far_lo_q;
	logic [POS_W-1:0]   wp_q;         // next word position of the stream
	logic               fin_q;

	// copy engine
	logic [SRC_W-1:0]   src_q;        // two's complement source index
	logic [BYTE_W-1:0]  rem_q;
	logic [COUNT_W-1:0] iss_cnt_q;    // words issued into the current group

	// word stage: RAM data returns here, word is written back and appended
	logic               v_s2;
	logic               lit_s2;
	logic [WORD_W-1:0]  lit_w_s2;
	logic               ok_s2;
	logic               fwd_s2;
	logic [WORD_W-1:0]  fwd_w_s2;
	logic [POS_W-1:0]   pos_s2;
	logic               last_s2;

	// group assembly
	logic [WORD_W-1:0]  grp_w_q [OUT_LANES];
	logic [COUNT_W-1:0] grp_cnt_q;
	logic               grp_bad_q;
	logic               grp_done_q;
	logic               grp_last_q;
	logic               grp_pend_q;

	// output register
	logic               out_v_q;
	logic [WORD_W-1:0]  out_w_q [OUT_LANES];
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_last_q;
	logic               out_done_q;
	logic               out_bad_q;

	// combinational
	logic [POS_W-1:0]   target;
	logic [WORD_W-1:0]  word_s2;
	logic               mem_we;
	logic [AW-1:0]      rd_addr;
	logic               issue;
	logic               src_ok;
	logic               out_free;
	logic               grp_full;
	logic               handoff;
	logic [WORD_W-1:0]  app_w [OUT_LANES];
	logic [COUNT_W-1:0] app_cnt;
	logic               app_bad;
	logic               app_done;
	logic               app_last;

	// per-item decode on acceptance
	logic               accept;
	phase_t             ph_eff;
	logic [POS_W-1:0]   wp_eff;
	logic               fin_eff;
	logic [BYTE_W-1:0]  b;

	assign target  = {1'b0, expanded_q[15:1]};
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign b       = s_axis_tdata;
	assign ph_eff  = s_axis_tuser ? PH_LOW : phase_q;
	assign wp_eff  = s_axis_tuser ? '0 : wp_q;
	assign fin_eff = s_axis_tuser ? 1'b0 : fin_q;

	assign s_axis_tready = (ct_q == CT_IDLE);

	// select the word-stage word: literal, unwritten source as zero, forwarded or RAM data
	always_comb begin
		if (lit_s2) begin
			word_s2 = lit_w_s2;
		end else if (!ok_s2) begin
			word_s2 = '0;
		end else if (fwd_s2) begin
			word_s2 = fwd_w_s2;
		end else begin
			word_s2 = rd_q;
		end
	end

	assign mem_we  = v_s2 && (pos_s2 < HW_POS);
	assign rd_addr = src_q[AW-1:0];
	assign issue   = (ct_q == CT_RUN) && (rem_q != '0) && (iss_cnt_q < GW_CNT);
	assign src_ok  = !src_q[SRC_W-1] && (src_q[SRC_W-2:0] < {1'b0, wp_q})
	                 && (src_q[SRC_W-2:0] < HW_SRC);

	// merge the arriving word into the group under assembly
	always_comb begin
		for (int i = 0; i < OUT_LANES; i++) begin
			app_w[i] = (v_s2 && (grp_cnt_q == COUNT_W'(i))) ? word_s2 : grp_w_q[i];
		end
		app_cnt  = v_s2 ? COUNT_W'(grp_cnt_q + 1'b1) : grp_cnt_q;
		app_bad  = grp_bad_q || (v_s2 && !lit_s2 && !ok_s2);
		app_done = v_s2 ? (({1'b0, pos_s2} + 17'd1) >= {1'b0, target}) : grp_done_q;
		app_last = v_s2 ? last_s2 : grp_last_q;
	end

	assign out_free = !out_v_q || m_axis_tready;
	assign grp_full = v_s2 && ((app_cnt == GW_CNT) || last_s2);
	assign handoff  = (grp_full || grp_pend_q) && out_free;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[pos_s2[AW-1:0]] <= word_s2;
		end
		rd_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expanded_q <= '0;
			phase_q    <= PH_LOW;
			ct_q       <= CT_IDLE;
			held_low_q <= '0;
			kind_q     <= 1'b0;
			far_lo_q   <= '0;
			wp_q       <= '0;
			fin_q      <= 1'b0;
			src_q      <= '0;
			rem_q      <= '0;
			iss_cnt_q  <= '0;
			v_s2       <= 1'b0;
			lit_s2     <= 1'b0;
			lit_w_s2   <= '0;
			ok_s2      <= 1'b0;
			fwd_s2     <= 1'b0;
			fwd_w_s2   <= '0;
			pos_s2     <= '0;
			last_s2    <= 1'b0;
			for (int i = 0; i < OUT_LANES; i++) begin
				grp_w_q[i] <= '0;
				out_w_q[i] <= '0;
			end
			grp_cnt_q  <= '0;
			grp_bad_q  <= 1'b0;
			grp_done_q <= 1'b0;
			grp_last_q <= 1'b0;
			grp_pend_q <= 1'b0;
			out_v_q    <= 1'b0;
			out_cnt_q  <= '0;
			out_last_q <= 1'b0;
			out_done_q <= 1'b0;
			out_bad_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				expanded_q <= cfg_wr_data;
			end

			v_s2 <= 1'b0;

			// drop the output item once taken
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			// hand a finished group to the output register, or hold it
			if (handoff) begin
				out_v_q    <= 1'b1;
				for (int i = 0; i < OUT_LANES; i++) begin
					out_w_q[i] <= (COUNT_W'(i) < app_cnt) ? app_w[i] : '0;
				end
				out_cnt_q  <= app_cnt;
				out_last_q <= app_last;
				out_done_q <= app_done;
				out_bad_q  <= app_bad;
				grp_cnt_q  <= '0;
				grp_bad_q  <= 1'b0;
				grp_done_q <= 1'b0;
				grp_last_q <= 1'b0;
				grp_pend_q <= 1'b0;
				iss_cnt_q  <= '0;
			end else if (v_s2) begin
				grp_w_q    <= app_w;
				grp_cnt_q  <= app_cnt;
				grp_bad_q  <= app_bad;
				grp_done_q <= app_done;
				grp_last_q <= app_last;
				grp_pend_q <= grp_full;
			end

			// the stream finishes when the last word of a run reaches the target
			if (v_s2 && last_s2 && app_done) begin
				fin_q <= 1'b1;
			end

			unique case (ct_q)
				CT_IDLE: begin
					if (accept) begin
						if (s_axis_tuser) begin
							phase_q    <= PH_LOW;
							held_low_q <= '0;
							kind_q     <= 1'b0;
							far_lo_q   <= '0;
							wp_q       <= '0;
							fin_q      <= 1'b0;
						end
						if (fin_eff || (wp_eff >= target)) begin
							// finished stream: swallow the byte
							fin_q <= 1'b1;
						end else begin
							unique case (ph_eff)
								PH_HIGH: begin
									if ((b == NEAR_TAG) || (b == FAR_TAG)) begin
										kind_q <= (b == FAR_TAG);
										if (held_low_q == '0) begin
											phase_q <= PH_ESCAPE;
										end else if (b == FAR_TAG) begin
											phase_q <= PH_FAR_LO;
										end else begin
											phase_q <= PH_NEAR_DIST;
										end
									end else begin
										v_s2     <= 1'b1;
										lit_s2   <= 1'b1;
										lit_w_s2 <= {b, held_low_q};
										ok_s2    <= 1'b1;
										fwd_s2   <= 1'b0;
										pos_s2   <= wp_eff;
										last_s2  <= 1'b1;
										wp_q     <= POS_W'(wp_eff + 1'b1);
										phase_q  <= PH_LOW;
										ct_q     <= CT_RUN;
									end
								end
								PH_ESCAPE: begin
									v_s2     <= 1'b1;
									lit_s2   <= 1'b1;
									lit_w_s2 <= {(kind_q ? FAR_TAG : NEAR_TAG), b};
									ok_s2    <= 1'b1;
									fwd_s2   <= 1'b0;
									pos_s2   <= wp_eff;
									last_s2  <= 1'b1;
									wp_q     <= POS_W'(wp_eff + 1'b1);
									phase_q  <= PH_LOW;
									ct_q     <= CT_RUN;
								end
								PH_NEAR_DIST: begin
									src_q   <= {2'b00, wp_eff} - {{(SRC_W-BYTE_W){1'b0}}, b};
									rem_q   <= held_low_q;
									phase_q <= PH_LOW;
									ct_q    <= CT_RUN;
								end
								PH_FAR_LO: begin
									far_lo_q <= b;
									phase_q  <= PH_FAR_HI;
								end
								PH_FAR_HI: begin
									src_q   <= {2'b00, b, far_lo_q};
									rem_q   <= held_low_q;
									phase_q <= PH_LOW;
									ct_q    <= CT_RUN;
								end
								default: begin
									held_low_q <= b;
									phase_q    <= PH_HIGH;
								end
							endcase
						end
					end
				end
				CT_RUN: begin
					if (issue) begin
						// read the source; forward a word written in this very cycle
						v_s2      <= 1'b1;
						lit_s2    <= 1'b0;
						ok_s2     <= src_ok;
						fwd_s2    <= mem_we && (pos_s2[AW-1:0] == rd_addr);
						fwd_w_s2  <= word_s2;
						pos_s2    <= wp_q;
						last_s2   <= (rem_q == 8'd1);
						src_q     <= SRC_W'(src_q + 1'b1);
						rem_q     <= BYTE_W'(rem_q - 1'b1);
						wp_q      <= POS_W'(wp_q + 1'b1);
						iss_cnt_q <= COUNT_W'(iss_cnt_q + 1'b1);
					end else if ((rem_q == '0) && !v_s2 && !grp_pend_q) begin
						ct_q <= CT_IDLE;
					end
				end
				default: begin
					ct_q <= CT_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'b0, out_cnt_q, out_w_q[3], out_w_q[2], out_w_q[1], out_w_q[0]};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_bad_q, out_done_q};

	// a new byte is only taken once the previous run has left the word stage and group assembly
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (!v_s2 && !grp_pend_q && (grp_cnt_q == '0)))
		else $error("byte taken while words still in flight");

	// a held group only waits behind a busy output register
	a_pend_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		grp_pend_q |-> out_v_q)
		else $error("group held while output register free");

	// never issue past a group boundary
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(iss_cnt_q <= GW_CNT) && (grp_cnt_q <= GW_CNT))
		else $error("group overfilled");

	// output groups carry between one and GROUP_WORDS words
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_cnt_q != '0) && (out_cnt_q <= GW_CNT)))
		else $error("bad word count on output");

	// forwarding only ever serves a RAM copy word
	a_fwd_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && fwd_s2) |-> !lit_s2)
		else $error("forward flagged on a literal word");

endmodule
